FILE: sv/cdts_pkg.sv
// Shared types and constants of the card list with shuffle.
// Holds field widths, operation and result codes, controller states and the
// command and status structs between controller and datapath. No dependencies.
package cdts_pkg;

	// payload field widths
	localparam int CMD_W     = 3;
	localparam int ID_W      = 16;
	localparam int POS_W     = 6;
	localparam int STAT_W    = 3;
	localparam int CNT_OUT_W = 7;
	localparam int RNG_W     = 32;

	// operation codes of the command field
	typedef enum logic [CMD_W-1:0] {
		OP_APPEND  = 3'd0,
		OP_REMOVE  = 3'd1,
		OP_DRAW    = 3'd2,
		OP_SHUFFLE = 3'd3,
		OP_READ    = 3'd4
	} op_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		RS_OK        = 3'd0,
		RS_NOT_FOUND = 3'd1,
		RS_EMPTY     = 3'd2,
		RS_FULL      = 3'd3,
		RS_RANGE     = 3'd4
	} rstat_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_WALK,
		ST_RNG,
		ST_MOD,
		ST_RDJ,
		ST_SWAP1,
		ST_SWAP2,
		ST_FIN
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic   accept;
		logic   do_append;
		logic   set_status;
		rstat_t status_val;
		logic   rd_pos;
		logic   cap_found;
		logic   walk_init;
		logic   walk_en;
		logic   sh_init;
		logic   sh_rng;
		logic   sh_cap;
		logic   sh_rd_j;
		logic   sh_wr_top;
		logic   sh_wr_j;
		logic   load_rsp;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		op_t  op;
		logic full;
		logic empty;
		logic few;
		logic pos_bad;
		logic walk_last;
		logic mod_done;
		logic sh_last;
	} dp_sts_t;

endpackage

FILE: sv/cdts_if.sv
// Channel interfaces of the card list: request, response and seed write.
// Each carries valid, ready and its payload. Depends on cdts_pkg.

// request channel
interface cdts_req_if import cdts_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [ID_W-1:0]  card_id;
	logic [POS_W-1:0] position;

	modport source (output valid, command, card_id, position, input ready);
	modport sink (input valid, command, card_id, position, output ready);
endinterface

// response channel
interface cdts_rsp_if import cdts_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [ID_W-1:0]      found_id;
	logic [STAT_W-1:0]    status;
	logic [CNT_OUT_W-1:0] entry_count;

	modport source (output valid, found_id, status, entry_count, input ready);
	modport sink (input valid, found_id, status, entry_count, output ready);
endinterface

// seed write channel
interface cdts_cfg_if import cdts_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RNG_W-1:0] rng_seed;

	modport source (output valid, rng_seed, input ready);
	modport sink (input valid, rng_seed, output ready);
endinterface

FILE: sv/cdts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cdts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/cdts_mod.sv
// Iterative remainder unit: 32-bit dividend modulo a narrow divisor,
// one dividend bit per cycle. Depends on cdts_pkg.
module cdts_mod import cdts_pkg::*; #(
	parameter int DW = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RNG_W-1:0] dividend,
	input  logic [DW-1:0]    divisor,
	output logic             done,
	output logic [DW-1:0]    rem
);

	localparam int CNT_W = $clog2(RNG_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RNG_W-1:0] dvd_q;
	logic [DW-1:0]    dvs_q;
	logic [DW-1:0]    rem_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;
	logic [DW-1:0]    rem_nx;

	// restoring step: bring in the next dividend bit, subtract when it fits
	always_comb begin
		trial  = {rem_q, dvd_q[RNG_W-1]};
		diff   = trial - {1'b0, dvs_q};
		rem_nx = (trial >= {1'b0, dvs_q}) ? diff[DW-1:0] : trial[DW-1:0];
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && cnt_q == CNT_W'(RNG_W - 1)) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	// operands and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			dvd_q <= {dvd_q[RNG_W-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: sv/cdts_dp.sv
// Datapath of the card list: entry memory, count, xorshift generator,
// walk and shuffle registers and the result register.
// Depends on cdts_pkg, cdts_ram and cdts_mod.
module cdts_dp import cdts_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_cmd_t            cm,
	output dp_sts_t              st,
	input  logic [CMD_W-1:0]     command,
	input  logic [ID_W-1:0]      card_id,
	input  logic [POS_W-1:0]     position,
	input  logic                 cfg_we,
	input  logic [RNG_W-1:0]     cfg_data,
	output logic [ID_W-1:0]      found_id,
	output logic [STAT_W-1:0]    status,
	output logic [CNT_OUT_W-1:0] entry_count
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

	// xorshift32 with shifts 13, 17, 5
	function automatic logic [RNG_W-1:0] xs_next(input logic [RNG_W-1:0] s);
		logic [RNG_W-1:0] x;
		x = s ^ (s << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

	logic [CW-1:0]        count_q;
	logic [RNG_W-1:0]     rng_q;
	logic [RNG_W-1:0]     rng_nx;
	logic [CMD_W-1:0]     cmd_q;
	logic [ID_W-1:0]      id_q;
	logic [POS_W-1:0]     pos_q;
	logic [ID_W-1:0]      found_q;
	rstat_t               status_q;
	logic [CW-1:0]        rd_idx_q;
	logic                 pend_v_q;
	logic [AW-1:0]        pend_idx_q;
	logic                 hit_q;
	logic [CW-1:0]        sh_i_q;
	logic [AW-1:0]        j_q;
	logic [ID_W-1:0]      tval_q;
	logic [ID_W-1:0]      rsp_found_q;
	rstat_t               rsp_status_q;
	logic [CW-1:0]        rsp_count_q;

	logic                 we;
	logic [AW-1:0]        waddr;
	logic [ID_W-1:0]      wdata;
	logic [AW-1:0]        raddr;
	logic [ID_W-1:0]      rdata;
	logic [AW-1:0]        top_a;
	logic                 issue;
	logic                 match_now;
	logic                 walk_last;
	logic                 mod_done;
	logic [CW-1:0]        mod_rem;

	// entry store
	cdts_ram #(
		.WIDTH (ID_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// swap partner: generator output modulo i
	cdts_mod #(
		.DW (CW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cm.sh_rng),
		.dividend (rng_nx),
		.divisor  (sh_i_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// walk and shuffle helpers
	always_comb begin
		rng_nx    = xs_next(rng_q);
		top_a     = AW'(sh_i_q - CW'(1));
		issue     = rd_idx_q < count_q;
		match_now = pend_v_q && !hit_q &&
			((op_t'(cmd_q) == OP_DRAW) ? (pend_idx_q == '0) : (rdata == id_q));
		walk_last = pend_v_q && (CW'(pend_idx_q) == count_q - CW'(1));
	end

	// memory read address
	always_comb begin
		if (cm.rd_pos) begin
			raddr = AW'(pos_q);
		end else if (cm.walk_en) begin
			raddr = rd_idx_q[AW-1:0];
		end else if (cm.sh_rd_j) begin
			raddr = j_q;
		end else begin
			raddr = top_a;
		end
	end

	// memory write port
	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = id_q;
		if (cm.do_append) begin
			we = 1'b1;
		end else if (cm.walk_en && pend_v_q && hit_q) begin
			we    = 1'b1;
			waddr = pend_idx_q - AW'(1);
			wdata = rdata;
		end else if (cm.sh_wr_top) begin
			we    = 1'b1;
			waddr = top_a;
			wdata = rdata;
		end else if (cm.sh_wr_j) begin
			we    = 1'b1;
			waddr = j_q;
			wdata = tval_q;
		end
	end

	// count, generator and walk flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rng_q    <= RNG_W'(1);
			pend_v_q <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				rng_q <= cfg_data;
			end else if (cm.sh_rng) begin
				rng_q <= rng_nx;
			end
			if (cm.do_append) begin
				count_q <= count_q + CW'(1);
			end else if (cm.walk_en && walk_last && (hit_q || match_now)) begin
				count_q <= count_q - CW'(1);
			end
			if (cm.walk_init) begin
				pend_v_q <= 1'b0;
				hit_q    <= 1'b0;
			end else if (cm.walk_en) begin
				pend_v_q <= issue;
				if (match_now) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// item, working and result registers
	always_ff @(posedge clk) begin
		if (cm.accept) begin
			cmd_q    <= command;
			id_q     <= card_id;
			pos_q    <= position;
			found_q  <= '0;
			status_q <= RS_OK;
		end
		if (cm.set_status) begin
			status_q <= cm.status_val;
		end
		if (cm.cap_found) begin
			found_q <= rdata;
		end
		if (cm.walk_en && match_now && op_t'(cmd_q) == OP_DRAW) begin
			found_q <= rdata;
		end
		if (cm.walk_en && walk_last && !(hit_q || match_now)) begin
			status_q <= RS_NOT_FOUND;
		end
		if (cm.walk_init) begin
			rd_idx_q <= '0;
		end else if (cm.walk_en) begin
			if (issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			pend_idx_q <= rd_idx_q[AW-1:0];
		end
		if (cm.sh_init) begin
			sh_i_q <= count_q;
		end else if (cm.sh_wr_j) begin
			sh_i_q <= sh_i_q - CW'(1);
		end
		if (cm.sh_cap) begin
			j_q    <= AW'(mod_rem);
			tval_q <= rdata;
		end
		if (cm.load_rsp) begin
			rsp_found_q  <= found_q;
			rsp_status_q <= status_q;
			rsp_count_q  <= count_q;
		end
	end

	// status towards the controller
	always_comb begin
		st.op        = op_t'(cmd_q);
		st.full      = count_q == CW'(DEPTH);
		st.empty     = count_q == '0;
		st.few       = count_q < CW'(2);
		st.pos_bad   = CMP_W'(pos_q) >= CMP_W'(count_q);
		st.walk_last = walk_last;
		st.mod_done  = mod_done;
		st.sh_last   = sh_i_q == CW'(2);
	end

	assign found_id    = rsp_found_q;
	assign status      = rsp_status_q;
	assign entry_count = CNT_OUT_W'(rsp_count_q);

endmodule

FILE: sv/cdts_ctrl.sv
// Controller of the card list: sequences one item at a time through
// decode, memory read, memory walk or shuffle swaps and result hand-off. Depends on cdts_pkg.
module cdts_ctrl import cdts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  dp_sts_t   st,
	output ctrl_cmd_t cm
);

	state_t state_q;
	state_t state_nx;
	logic   rsp_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cm.load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_nx  = state_q;
		cm        = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cm.accept = 1'b1;
					state_nx  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_nx = ST_FIN;
				case (st.op)
					OP_APPEND: begin
						if (st.full) begin
							cm.set_status = 1'b1;
							cm.status_val = RS_FULL;
						end else begin
							cm.do_append = 1'b1;
						end
					end
					OP_READ: begin
						if (st.pos_bad) begin
							cm.set_status = 1'b1;
							cm.status_val = RS_RANGE;
						end else begin
							cm.rd_pos = 1'b1;
							state_nx  = ST_READ;
						end
					end
					OP_DRAW: begin
						if (st.empty) begin
							cm.set_status = 1'b1;
							cm.status_val = RS_EMPTY;
						end else begin
							cm.walk_init = 1'b1;
							state_nx     = ST_WALK;
						end
					end
					OP_REMOVE: begin
						if (st.empty) begin
							cm.set_status = 1'b1;
							cm.status_val = RS_NOT_FOUND;
						end else begin
							cm.walk_init = 1'b1;
							state_nx     = ST_WALK;
						end
					end
					OP_SHUFFLE: begin
						if (!st.few) begin
							cm.sh_init = 1'b1;
							state_nx   = ST_RNG;
						end
					end
					default: begin
						state_nx = ST_FIN;
					end
				endcase
			end
			ST_READ: begin
				cm.cap_found = 1'b1;
				state_nx     = ST_FIN;
			end
			ST_WALK: begin
				cm.walk_en = 1'b1;
				if (st.walk_last) begin
					state_nx = ST_FIN;
				end
			end
			ST_RNG: begin
				cm.sh_rng = 1'b1;
				state_nx  = ST_MOD;
			end
			ST_MOD: begin
				if (st.mod_done) begin
					cm.sh_cap = 1'b1;
					state_nx  = ST_RDJ;
				end
			end
			ST_RDJ: begin
				cm.sh_rd_j = 1'b1;
				state_nx   = ST_SWAP1;
			end
			ST_SWAP1: begin
				cm.sh_wr_top = 1'b1;
				state_nx     = ST_SWAP2;
			end
			ST_SWAP2: begin
				cm.sh_wr_j = 1'b1;
				state_nx   = st.sh_last ? ST_FIN : ST_RNG;
			end
			ST_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					cm.load_rsp = 1'b1;
					state_nx    = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

FILE: sv/card_deck_table_with_shuffle_core.sv
// Card list with shuffle: ordered list of up to DEPTH 16-bit card ids.
// Channels: req (command, card_id, position), rsp (found_id, status,
// entry_count), cfg (rng_seed write, always ready, loads the generator).
// One item is worked at a time; one result item per request item.
// Steps from accept to result register loaded:
//   append, no-op, refused commands: decode; read: decode, memory read
//   draw, remove: decode, then one memory read per cycle walks the list
//   shuffle: decode, then count - 1 swaps; each swap is set by the
//   bit-serial remainder unit plus read and two writes on the
//   entry memory with its single write port
// The result sits in an output register, so the next item is accepted while
// it waits; a stalled receiver holds the block only when the following
// result is ready to be loaded.
// Reset: list empty, generator state 1, no result pending. The entry
// memory needs no clearing; only entries below the count are ever read.
// Depends on cdts_pkg, cdts_if, cdts_ctrl and cdts_dp.
module card_deck_table_with_shuffle_core import cdts_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	cdts_req_if.sink          req,
	cdts_rsp_if.source        rsp,
	cdts_cfg_if.sink          cfg
);

	ctrl_cmd_t cm;
	dp_sts_t   st;

	// sequencer
	cdts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.st        (st),
		.cm        (cm)
	);

	// storage and arithmetic
	cdts_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cm          (cm),
		.st          (st),
		.command     (req.command),
		.card_id     (req.card_id),
		.position    (req.position),
		.cfg_we      (cfg.valid),
		.cfg_data    (cfg.rng_seed),
		.found_id    (rsp.found_id),
		.status      (rsp.status),
		.entry_count (rsp.entry_count)
	);

	// seed writes are taken at once
	assign cfg.ready = 1'b1;

endmodule
